// ----- hdl/sms_pkg.sv -----
// Shared types and constants for the sparse membership set.
package sms_pkg;

  localparam int unsigned VALUE_W      = 10;
  localparam int unsigned CFG_W        = 11;
  localparam int unsigned COUNT_OUT_W  = 11;
  localparam int unsigned UNIVERSE_DEF = 1024;
  localparam logic [CFG_W-1:0] UNIV_SIZE_RST = 11'd1024;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TEST   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

// ----- hdl/sms_ctrl.sv -----
// Request sequencer: capture, lookup, execute.
module sms_ctrl
  import sms_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        if (!sts_i.out_busy) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_capture_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_LOOK))
    else $error("capture not followed by lookup");

  a_look_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.lookup |=> (state_q == S_EXEC))
    else $error("lookup not followed by execute");

  a_exec_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> !sts_i.out_busy)
    else $error("execute while result register busy");

endmodule

// ----- hdl/sms_dpath.sv -----
// Datapath: member list and position map memories, count, result register.
module sms_dpath
  import sms_pkg::*;
#(
  parameter int unsigned UNIVERSE = UNIVERSE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [1:0]             req_i,
  input  logic [VALUE_W-1:0]     value_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_ok_o,
  output logic [COUNT_OUT_W-1:0] out_count_o
);

  localparam int unsigned IW = $clog2(UNIVERSE);
  localparam int unsigned CW = $clog2(UNIVERSE + 1);

  logic [VALUE_W-1:0] mlist_mem [UNIVERSE];
  logic [IW-1:0]      pmap_mem  [UNIVERSE];

  logic [CFG_W-1:0]   univ_q;
  logic [CW-1:0]      count_q, count_d;
  req_e               req_q;
  logic [VALUE_W-1:0] value_q;
  logic [IW-1:0]      pmap_rd_q;
  logic [VALUE_W-1:0] mlist_rd_q;
  logic [VALUE_W-1:0] last_q;
  logic               out_valid_q;
  logic               out_ok_q;
  logic [CW-1:0]      out_count_q;

  logic [IW-1:0]      mlist_raddr;
  logic               in_range, is_member, ok;
  logic               mlist_we, pmap_we;
  logic [IW-1:0]      mlist_waddr, pmap_waddr;
  logic [VALUE_W-1:0] mlist_wdata;
  logic [IW-1:0]      pmap_wdata;

  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // read address: last slot on capture, looked-up slot afterwards
  assign mlist_raddr = cmd_i.capture ? IW'(count_q - CW'(1)) : pmap_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pmap_rd_q <= pmap_mem[IW'(value_i)];
    end
    if (cmd_i.capture || cmd_i.lookup) begin
      mlist_rd_q <= mlist_mem[mlist_raddr];
    end
    if (cmd_i.lookup) begin
      last_q <= mlist_rd_q;
    end
    if (cmd_i.capture) begin
      req_q   <= req_e'(req_i);
      value_q <= value_i;
    end
  end

  assign in_range  = (CFG_W'(value_q) < univ_q) && (32'(value_q) < 32'(UNIVERSE));
  assign is_member = in_range && (CW'(pmap_rd_q) < count_q) && (mlist_rd_q == value_q);

  always_comb begin
    ok          = 1'b0;
    count_d     = count_q;
    mlist_we    = 1'b0;
    pmap_we     = 1'b0;
    mlist_waddr = IW'(count_q);
    mlist_wdata = value_q;
    pmap_waddr  = IW'(value_q);
    pmap_wdata  = IW'(count_q);
    unique case (req_q)
      REQ_INSERT: begin
        if (in_range && !is_member && (count_q < CW'(UNIVERSE))) begin
          ok       = 1'b1;
          mlist_we = 1'b1;
          pmap_we  = 1'b1;
          count_d  = count_q + CW'(1);
        end
      end
      REQ_REMOVE: begin
        mlist_waddr = pmap_rd_q;
        mlist_wdata = last_q;
        pmap_waddr  = IW'(last_q);
        pmap_wdata  = pmap_rd_q;
        if (is_member) begin
          ok       = 1'b1;
          mlist_we = 1'b1;
          pmap_we  = 1'b1;
          count_d  = count_q - CW'(1);
        end
      end
      REQ_TEST: ok = is_member;
      REQ_CLEAR: begin
        ok      = 1'b1;
        count_d = '0;
      end
      default: ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mlist_we) begin
      mlist_mem[mlist_waddr] <= mlist_wdata;
    end
    if (cmd_i.exec && pmap_we) begin
      pmap_mem[pmap_waddr] <= pmap_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      univ_q      <= UNIV_SIZE_RST;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        univ_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_ok_q    <= ok;
      out_count_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ok_o    = out_ok_q;
  assign out_count_o = COUNT_OUT_W'(out_count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(UNIVERSE))
    else $error("member count above universe");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(count_q))
    else $error("count changed outside execute");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (req_q == REQ_CLEAR)) |=> (count_q == '0) && out_valid_q)
    else $error("clear did not empty the set");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (out_count_q == count_q))
    else $error("result count differs from stored count");

endmodule

// ----- hdl/sparse_membership_set_top.sv -----
// Top level of the sparse membership set.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tuser[1:0] req_type, tdata[9:0] value
//  m_axis    out  m_axis_tvalid/tready        tdata[0] ok, tdata[11:1] member_count
//  cfg       in   cfg_we_i                    cfg_wdata_i universe_size
//
//  Each request passes through capture with map read, member list read, and execute
//  with memory writes; the dependent reads through the single-port memories set this order.
//  A new request is taken while the previous result still waits in the output register;
//  execute stalls only while that register is full and m_axis_tready is low.
//  Reset empties the set (count only) and sets universe_size to 1024; memories need
//  no clearing pass.
module sparse_membership_set_top
  import sms_pkg::*;
#(
  parameter int unsigned UNIVERSE = UNIVERSE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // [9:0] value
  input  logic [1:0]       s_axis_tuser,   // [1:0] req_type
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [0] ok, [11:1] member_count
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  cmd_t                   cmd;
  sts_t                   sts;
  logic                   out_ok;
  logic [COUNT_OUT_W-1:0] out_count;

  sms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sms_dpath #(
    .UNIVERSE (UNIVERSE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (s_axis_tuser),
    .value_i     (s_axis_tdata[VALUE_W-1:0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ok_o    (out_ok),
    .out_count_o (out_count)
  );

  assign m_axis_tdata = {4'b0, out_count, out_ok};

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the sparse membership set: stream driver, monitor, set model.
module testbench;
  import sms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SPAN = UNIVERSE_DEF;

  typedef struct {
    req_e                 kind;
    logic [VALUE_W-1:0]   value;
  } req_item_t;

  typedef struct {
    logic                   ok;
    logic [COUNT_OUT_W-1:0] count;
  } set_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata = '0;
  logic [1:0]       s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = UNIV_SIZE_RST;

  req_item_t   pending_reqs[$];
  set_result_t expected_results[$];

  // set model state
  logic [VALUE_W-1:0]     members [SPAN];
  logic [VALUE_W-1:0]     slot_of [SPAN];
  logic [COUNT_OUT_W-1:0] set_count = '0;
  logic [CFG_W-1:0]       universe_size_q = UNIV_SIZE_RST;

  bit          idle_on = 1'b1;
  bit          hold_out = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned accept_count = 0;
  int unsigned error_count = 0;

  sparse_membership_set_top #(.UNIVERSE(SPAN)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [CFG_W-1:0] value_limit();
    return (universe_size_q < CFG_W'(SPAN)) ? universe_size_q : CFG_W'(SPAN);
  endfunction

  function automatic bit holds_value(logic [VALUE_W-1:0] v);
    logic [COUNT_OUT_W-1:0] pos;
    if ({1'b0, v} >= value_limit()) return 1'b0;
    pos = {1'b0, slot_of[v]};
    return (pos < set_count) && (members[pos[VALUE_W-1:0]] == v);
  endfunction

  task automatic predict_request(req_item_t r);
    set_result_t        res;
    logic [VALUE_W-1:0] hole;
    logic [VALUE_W-1:0] moved;
    res.ok = 1'b0;
    case (r.kind)
      REQ_INSERT: begin
        if ({1'b0, r.value} < value_limit() && !holds_value(r.value) &&
            set_count < COUNT_OUT_W'(SPAN)) begin
          members[set_count[VALUE_W-1:0]] = r.value;
          slot_of[r.value] = set_count[VALUE_W-1:0];
          set_count++;
          res.ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (holds_value(r.value)) begin
          hole = slot_of[r.value];
          set_count--;
          moved = members[set_count[VALUE_W-1:0]];
          members[hole] = moved;
          slot_of[moved] = hole;
          res.ok = 1'b1;
        end
      end
      REQ_TEST: res.ok = holds_value(r.value);
      default: begin
        set_count = '0;
        res.ok = 1'b1;
      end
    endcase
    res.count = set_count;
    expected_results.push_back(res);
  endtask

  function automatic void queue_req(req_e kind, int unsigned v);
    req_item_t item;
    item.kind = kind;
    item.value = VALUE_W'(v);
    pending_reqs.push_back(item);
  endfunction

  // mostly values from a window so that hits are frequent, some from the full field
  function automatic void queue_random(int unsigned base, int unsigned width);
    int unsigned pick;
    int unsigned v;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) v = $urandom_range(0, SPAN - 1);
    else v = base + $urandom_range(0, width - 1);
    if (pick < 40) queue_req(REQ_INSERT, v);
    else if (pick < 65) queue_req(REQ_REMOVE, v);
    else if (pick < 97) queue_req(REQ_TEST, v);
    else queue_req(REQ_CLEAR, $urandom_range(0, SPAN - 1));
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_universe(logic [CFG_W-1:0] size);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    universe_size_q = size;
  endtask

  task automatic random_phase(logic [CFG_W-1:0] size, int unsigned base, int unsigned width,
                              int unsigned n);
    write_universe(size);
    for (int unsigned i = 0; i < n; i++) queue_random(base, width);
    wait_idle();
  endtask

  // request driver
  always @(posedge clk_i) begin : drive
    req_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        item = pending_reqs.pop_front();
        predict_request(item);
        accept_count++;
      end
      if (send_gap == 0 && idle_on && !hold_out && $urandom_range(0, 4) == 0)
        send_gap = $urandom_range(1, 9);
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(16-VALUE_W){1'b0}}, pending_reqs[0].value};
        s_axis_tuser <= pending_reqs[0].kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : watch
    set_result_t exp_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result transfer, tdata=%h", m_axis_tdata));
        end else begin
          exp_res = expected_results.pop_front();
          if (m_axis_tdata[0] !== exp_res.ok)
            report_mismatch($sformatf("ok: got %b, expected %b", m_axis_tdata[0], exp_res.ok));
          if (m_axis_tdata[COUNT_OUT_W:1] !== exp_res.count)
            report_mismatch($sformatf("member_count: got %0d, expected %0d",
                                      m_axis_tdata[COUNT_OUT_W:1], exp_res.count));
        end
      end
      if (hold_out) begin
        m_axis_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin : hold_off
    wait (accept_count >= 200);
    @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  initial begin : watchdog
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned perm [SPAN];
    int unsigned j;
    int unsigned tmp;
    int unsigned lim;
    for (int unsigned i = 0; i < SPAN; i++) begin
      members[i] = '0;
      slot_of[i] = '0;
      perm[i] = i;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // basic operations at the value extremes
    queue_req(REQ_TEST, 0);
    queue_req(REQ_REMOVE, 0);
    queue_req(REQ_INSERT, 0);
    queue_req(REQ_INSERT, 1023);
    queue_req(REQ_INSERT, 0);
    queue_req(REQ_TEST, 1023);
    queue_req(REQ_REMOVE, 1023);
    queue_req(REQ_REMOVE, 1023);
    queue_req(REQ_INSERT, 512);
    queue_req(REQ_REMOVE, 0);
    queue_req(REQ_TEST, 512);
    queue_req(REQ_CLEAR, 1023);
    queue_req(REQ_TEST, 512);
    queue_req(REQ_INSERT, 5);
    queue_req(REQ_INSERT, 6);
    queue_req(REQ_INSERT, 7);
    queue_req(REQ_REMOVE, 5);
    queue_req(REQ_TEST, 7);
    queue_req(REQ_REMOVE, 7);
    wait_idle();

    // empty universe, oversized universe, universe shrunk under members
    write_universe(11'd0);
    queue_req(REQ_INSERT, 0);
    queue_req(REQ_TEST, 6);
    queue_req(REQ_CLEAR, 0);
    wait_idle();
    write_universe(11'd2047);
    queue_req(REQ_INSERT, 1023);
    queue_req(REQ_INSERT, 10);
    wait_idle();
    write_universe(11'd100);
    queue_req(REQ_TEST, 1023);
    queue_req(REQ_REMOVE, 1023);
    queue_req(REQ_INSERT, 1023);
    queue_req(REQ_REMOVE, 10);
    wait_idle();
    write_universe(11'd1);
    queue_req(REQ_INSERT, 1);
    queue_req(REQ_INSERT, 0);
    wait_idle();

    // fill the whole universe in random order
    write_universe(11'd1024);
    queue_req(REQ_CLEAR, 0);
    for (int unsigned i = SPAN - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int unsigned i = 0; i < SPAN; i++) begin
      queue_req(REQ_INSERT, perm[i]);
      if ($urandom_range(0, 31) == 0) queue_req(REQ_TEST, $urandom_range(0, SPAN - 1));
    end
    queue_req(REQ_INSERT, $urandom_range(0, SPAN - 1));
    queue_req(REQ_REMOVE, perm[0]);
    queue_req(REQ_INSERT, perm[0]);
    queue_req(REQ_TEST, perm[SPAN - 1]);
    wait_idle();
    write_universe(11'd512);
    queue_req(REQ_TEST, 700);
    queue_req(REQ_REMOVE, 700);
    queue_req(REQ_INSERT, 700);
    queue_req(REQ_REMOVE, 100);
    queue_req(REQ_TEST, 100);
    queue_req(REQ_CLEAR, 0);
    wait_idle();

    // random traffic under several universe sizes
    idle_on = ($urandom_range(0, 3) != 0);
    random_phase(11'd2047, $urandom_range(0, SPAN - 96), 96, 40);
    idle_on = 1'b1;
    lim = $urandom_range(2, SPAN - 1);
    random_phase(CFG_W'(lim), (lim > 32) ? lim - 32 : 0, 40, 40);
    idle_on = ($urandom_range(0, 3) != 0);
    random_phase(11'd16, 0, 20, 30);
    idle_on = 1'b1;
    random_phase(11'd1, 0, 3, 12);
    random_phase(11'd0, 0, 4, 8);
    random_phase(11'd1024, $urandom_range(0, SPAN - 64), 64, 30);
    idle_on = 1'b0;
    random_phase(11'd1024, $urandom_range(0, SPAN - 48), 48, 40);

    repeat (20) @(posedge clk_i);
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sparse_membership_set_top.f -----
hdl/sms_pkg.sv
hdl/sms_ctrl.sv
hdl/sms_dpath.sv
hdl/sparse_membership_set_top.sv
dv/testbench.sv
